FILE: design/luhn_pkg.sv
// ----------------------------------------------------------------------------
// Luhn check package
// Shared constants, brand codes and digit helper functions.
// ----------------------------------------------------------------------------
package luhn_pkg;

    localparam int BIN_W      = 63;
    localparam int PAD_W      = 64;
    localparam int NUM_DIGITS = 19;
    localparam int BCD_W      = NUM_DIGITS * 4;
    localparam int DD_STAGES  = 8;
    localparam int DD_BITS    = PAD_W / DD_STAGES;
    localparam int MAX_DIGITS = 16;
    localparam int GROUPS     = 4;
    localparam int GROUP_LEN  = 5;

    typedef enum logic [1:0] {
        BRAND_INVALID    = 2'd0,
        BRAND_VISA       = 2'd1,
        BRAND_MASTERCARD = 2'd2,
        BRAND_AMEX       = 2'd3
    } t_brand;

    // Several double-dabble steps: adjust every digit, then shift one bit in.
    function automatic logic [BCD_W-1:0] dd_bits(input logic [BCD_W-1:0] bcd_in,
                                                 input logic [DD_BITS-1:0] bits);
        logic [BCD_W-1:0] bcd;
        bcd = bcd_in;
        for (int k = DD_BITS - 1; k >= 0; k--) begin
            for (int d = 0; d < NUM_DIGITS; d++) begin
                if (bcd[d*4 +: 4] >= 4'd5) begin
                    bcd[d*4 +: 4] = bcd[d*4 +: 4] + 4'd3;
                end
            end
            bcd = {bcd[BCD_W-2:0], bits[k]};
        end
        return bcd;
    endfunction

    // Luhn weight of the digit at a given position from the right.
    function automatic logic [3:0] luhn_map(input logic [3:0] dig, input logic odd);
        logic [4:0] dbl;
        dbl = {dig, 1'b0};
        if (!odd) begin
            return dig;
        end else if (dbl > 5'd9) begin
            return 4'(dbl - 5'd9);
        end else begin
            return dbl[3:0];
        end
    endfunction

endpackage

FILE: design/luhn_card_brand_check.sv
// Throughput: one item per cycle while the receiver does not stall the output;
// eight double-dabble stages of eight bits each set the depth, followed by three
// stages of digit counting, summing and decoding.
// Reset: i_rst_n is synchronous and active low; it clears all stage valid bits.
// ----------------------------------------------------------------------------
// Luhn card brand check
// Pipelined binary-to-decimal conversion, Luhn sum and card brand decode.
// ----------------------------------------------------------------------------
module luhn_card_brand_check (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [luhn_pkg::BIN_W-1:0] i_card_number,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic [1:0]               o_card_brand,
    output logic [7:0]               o_luhn_sum,
    output logic [4:0]               o_digit_count,
    output logic [6:0]               o_leading_pair
);
    import luhn_pkg::*;

    // The whole pipeline moves as one. It halts only when a finished result
    // sits in the output register and the receiver stalls it, so no transfer
    // is lost or repeated.
    logic en;
    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;

    // Double-dabble stages. Each stage consumes the top eight bits of the
    // zero-padded number and shifts them into the BCD accumulator.
    logic [BCD_W-1:0] r_dd_bcd [DD_STAGES];
    logic [PAD_W-1:0] r_dd_bin [DD_STAGES];
    logic             r_dd_vld [DD_STAGES];

    logic [PAD_W-1:0] in_pad;
    assign in_pad = {1'b0, i_card_number};

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dd_bcd[0] <= dd_bits('0, in_pad[PAD_W-1 -: DD_BITS]);
            r_dd_bin[0] <= in_pad << DD_BITS;
            for (int s = 1; s < DD_STAGES; s++) begin
                r_dd_bcd[s] <= dd_bits(r_dd_bcd[s-1], r_dd_bin[s-1][PAD_W-1 -: DD_BITS]);
                r_dd_bin[s] <= r_dd_bin[s-1] << DD_BITS;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < DD_STAGES; s++) begin
                r_dd_vld[s] <= 1'b0;
            end
        end else if (en) begin
            r_dd_vld[0] <= i_valid;
            for (int s = 1; s < DD_STAGES; s++) begin
                r_dd_vld[s] <= r_dd_vld[s-1];
            end
        end
    end

    // Stage 9: digit count and partial Luhn sums over groups of five digits.
    // Digits above the top one are zero and weigh zero, so all digits are summed.
    logic [BCD_W-1:0] digits;
    logic [4:0]       n_cnt;
    logic [5:0]       n_part [GROUPS];
    logic [BCD_W-1:0] r9_digits;
    logic [4:0]       r9_cnt;
    logic [5:0]       r9_part [GROUPS];
    logic             r9_vld;

    assign digits = r_dd_bcd[DD_STAGES-1];

    always_comb begin
        n_cnt = '0;
        for (int d = 0; d < NUM_DIGITS; d++) begin
            if (digits[d*4 +: 4] != 4'd0) begin
                n_cnt = 5'(d + 1);
            end
        end
        for (int g = 0; g < GROUPS; g++) begin
            n_part[g] = '0;
            for (int j = 0; j < GROUP_LEN; j++) begin
                if (g * GROUP_LEN + j < NUM_DIGITS) begin
                    n_part[g] = n_part[g] + 6'(luhn_map(
                        digits[(g*GROUP_LEN + j)*4 +: 4], 1'((g*GROUP_LEN + j) % 2)));
                end
            end
        end
    end

    // Stage 10: total sum and leading pair.
    logic [7:0] n_sum;
    logic [6:0] n_pair;
    logic [7:0] r10_sum;
    logic [4:0] r10_cnt;
    logic [6:0] r10_pair;
    logic       r10_vld;

    always_comb begin
        n_sum = 8'(r9_part[0]) + 8'(r9_part[1]) + 8'(r9_part[2]) + 8'(r9_part[3]);
        n_pair = '0;
        if (r9_cnt == 5'd1) begin
            n_pair = 7'(r9_digits[3:0]);
        end
        for (int d = 1; d < NUM_DIGITS; d++) begin
            if (r9_cnt == 5'(d + 1)) begin
                n_pair = 7'(r9_digits[d*4 +: 4]) * 7'd10 + 7'(r9_digits[(d-1)*4 +: 4]);
            end
        end
    end

    // Stage 11: length check, mod-10 test and brand decode into the output register.
    logic   len_ok;
    logic   mod_ok;
    t_brand n_brand;
    logic [1:0] r_brand;
    logic [7:0] r_sum;
    logic [4:0] r_cnt;
    logic [6:0] r_pair;
    logic       r_vld;

    always_comb begin
        len_ok = (r10_cnt >= 5'd13) && (r10_cnt != 5'd14) && (r10_cnt <= 5'(MAX_DIGITS));
        mod_ok = 1'b0;
        for (int k = 0; k < 18; k++) begin
            if (r10_sum == 8'(k * 10)) begin
                mod_ok = 1'b1;
            end
        end
        n_brand = BRAND_INVALID;
        if (len_ok && mod_ok) begin
            priority if (r10_pair >= 7'd40 && r10_pair < 7'd50) begin
                n_brand = BRAND_VISA;
            end else if (r10_pair >= 7'd51 && r10_pair <= 7'd55) begin
                n_brand = BRAND_MASTERCARD;
            end else if (r10_pair == 7'd34 || r10_pair == 7'd37) begin
                n_brand = BRAND_AMEX;
            end else begin
                n_brand = BRAND_INVALID;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r9_digits <= digits;
            r9_cnt    <= n_cnt;
            for (int g = 0; g < GROUPS; g++) begin
                r9_part[g] <= n_part[g];
            end
            r10_sum  <= n_sum;
            r10_cnt  <= r9_cnt;
            r10_pair <= n_pair;
            r_brand  <= n_brand;
            r_sum    <= len_ok ? r10_sum : 8'd0;
            r_cnt    <= r10_cnt;
            r_pair   <= r10_pair;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r9_vld  <= 1'b0;
            r10_vld <= 1'b0;
            r_vld   <= 1'b0;
        end else if (en) begin
            r9_vld  <= r_dd_vld[DD_STAGES-1];
            r10_vld <= r9_vld;
            r_vld   <= r10_vld;
        end
    end

    assign o_valid        = r_vld;
    assign o_card_brand   = r_brand;
    assign o_luhn_sum     = r_sum;
    assign o_digit_count  = r_cnt;
    assign o_leading_pair = r_pair;

`ifndef NO_ASSERTIONS
    a_brand_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_card_brand != BRAND_INVALID) |->
        (o_digit_count == 5'd13 || o_digit_count == 5'd15 || o_digit_count == 5'd16))
        else $error("brand reported for a rejected length");
    a_brand_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_card_brand != BRAND_INVALID) |-> (o_luhn_sum != 8'd0))
        else $error("brand reported with zero Luhn sum");
    a_short_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_digit_count < 5'd13) |-> (o_luhn_sum == 8'd0))
        else $error("Luhn sum reported for a short number");
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r10_vld && o_stall) |=> r10_vld)
        else $error("pipeline item lost during stall");
`endif

endmodule
